// File: design/double_ended_queue_defines.svh
// Assertion helpers for the checker file.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// same-cycle implication, quiet during reset
`define DEQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deque check failed");

// next-cycle implication, quiet during reset
`define DEQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deque check failed");

`endif

// File: design/deq_pkg.sv
package deq_pkg;

  typedef logic signed [31:0] word_t;

  localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [2:0] ACT_POP_BACK   = 3'd3;
  localparam logic [2:0] ACT_LIST_FWD   = 3'd4;
  localparam logic [2:0] ACT_LIST_BWD   = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    C_HOLD,
    C_PUSH_FRONT,
    C_PUSH_BACK,
    C_POP_FRONT,
    C_ROT_FWD,
    C_ROT_BWD
  } cell_op_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t op;
    word_t    value;  // word to store on a push
    word_t    wrap;   // word that wraps around the chain on a rotate
  } cell_cmd_t;

endpackage

// File: design/deq_cell.sv
module deq_cell import deq_pkg::*; #(
  parameter int IDX   = 0,
  parameter int OCC_W = 5
) (
  input  logic             clk,
  input  cell_cmd_t        cmd,
  input  logic [OCC_W-1:0] occ,
  input  word_t            left_data,
  input  word_t            right_data,
  output word_t            data
);

  localparam logic [OCC_W-1:0] IDX_V  = OCC_W'(IDX);
  localparam logic [OCC_W-1:0] IDX_P1 = OCC_W'(IDX + 1);

  word_t data_next;

  always_comb begin
    data_next = data;
    case (cmd.op)
      C_HOLD:       data_next = data;
      C_PUSH_FRONT: data_next = (IDX == 0) ? cmd.value : left_data;
      C_PUSH_BACK:  if (occ == IDX_V) data_next = cmd.value;
      C_POP_FRONT:  data_next = right_data;
      // the back cell takes the old front word
      C_ROT_FWD:    data_next = (occ == IDX_P1) ? cmd.wrap : right_data;
      // the front cell takes the old back word
      C_ROT_BWD:    data_next = (IDX == 0) ? cmd.wrap : left_data;
      default:      data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// File: design/double_ended_queue.sv
// Bounded deque of DEPTH signed 32-bit words, held in a chain of cells with the
// front word in cell 0. Push and pop beats are taken one per cycle while the
// result register is free or being drained; each returns one result. A listing
// emits its words one by one while the result register is free, as the chain
// rotates by one cell per emitted word until it is back in place; no new beat
// is taken during that time. Entry contents are not cleared by reset.
module double_ended_queue import deq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] action,
  input  word_t      value,
  output logic       out_valid,
  input  logic       out_ready,
  output word_t      word,
  output logic [1:0] status,
  output logic       last
);

  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH);
  localparam logic [OCC_W-1:0] ONE_OCC  = OCC_W'(1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LIST = 2'b10
  } state_t;

  state_t           state, state_next;
  logic [OCC_W-1:0] occ, occ_next;
  logic [OCC_W-1:0] remain, remain_next;
  logic             list_bwd, list_bwd_next;

  word_t            cell_data [DEPTH];
  cell_cmd_t        cmd;
  word_t            back_word;

  logic             slot_free;
  logic             accept;
  logic             emit;
  word_t            emit_word;
  logic [1:0]       emit_status;
  logic             emit_last;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;

  // word in the back cell; zero when empty
  always_comb begin
    back_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (occ == OCC_W'(i + 1)) back_word = back_word | cell_data[i];
    end
  end

  always_comb begin
    state_next    = state;
    occ_next      = occ;
    remain_next   = remain;
    list_bwd_next = list_bwd;
    cmd.op        = C_HOLD;
    cmd.value     = value;
    cmd.wrap      = '0;
    emit          = 1'b0;
    emit_word     = '0;
    emit_status   = ST_OK;
    emit_last     = 1'b1;

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (action)
            ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
              emit = 1'b1;
              if (occ == FULL_OCC) begin
                emit_status = ST_FULL;
              end else begin
                cmd.op   = (action == ACT_PUSH_FRONT) ? C_PUSH_FRONT : C_PUSH_BACK;
                occ_next = occ + ONE_OCC;
              end
            end
            ACT_POP_FRONT, ACT_POP_BACK: begin
              emit = 1'b1;
              if (occ == '0) begin
                emit_status = ST_EMPTY;
              end else if (action == ACT_POP_FRONT) begin
                emit_word = cell_data[0];
                cmd.op    = C_POP_FRONT;
                occ_next  = occ - ONE_OCC;
              end else begin
                emit_word = back_word;
                occ_next  = occ - ONE_OCC;
              end
            end
            ACT_LIST_FWD, ACT_LIST_BWD: begin
              if (occ == '0) begin
                emit        = 1'b1;
                emit_status = ST_EMPTY;
              end else begin
                state_next    = S_LIST;
                remain_next   = occ;
                list_bwd_next = (action == ACT_LIST_BWD);
              end
            end
            default: ;
          endcase
        end
      end
      S_LIST: begin
        if (slot_free) begin
          emit        = 1'b1;
          emit_word   = list_bwd ? back_word : cell_data[0];
          emit_last   = (remain == ONE_OCC);
          cmd.op      = list_bwd ? C_ROT_BWD : C_ROT_FWD;
          cmd.wrap    = emit_word;
          remain_next = remain - ONE_OCC;
          if (remain == ONE_OCC) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    word_t left_in, right_in;
    if (g == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = cell_data[g+1];
    end
    deq_cell #(
      .IDX   (g),
      .OCC_W (OCC_W)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .occ        (occ),
      .left_data  (left_in),
      .right_data (right_in),
      .data       (cell_data[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      remain    <= '0;
      list_bwd  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      occ       <= occ_next;
      remain    <= remain_next;
      list_bwd  <= list_bwd_next;
      out_valid <= emit || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      word   <= emit_word;
      status <= emit_status;
      last   <= emit_last;
    end
  end

endmodule

// File: design/deq_checker.sv
`include "double_ended_queue_defines.svh"

module deq_checker import deq_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input word_t      word,
  input logic [1:0] status,
  input logic       last
);

  // a result left waiting must not change under the consumer
  `DEQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(word) && $stable(status) && $stable(last))

  // a stuck result blocks the input side
  `DEQ_ASSERT_NOW(a_in_block, out_valid && !out_ready, !in_ready)

  // error results are single, zero-word beats
  `DEQ_ASSERT_NOW(a_err_shape, out_valid && status != ST_OK, word == '0 && last)

  // only listing beats can be non-final, and those are always ok
  `DEQ_ASSERT_NOW(a_mid_ok, out_valid && !last, status == ST_OK)

  // no status code beyond full
  `DEQ_ASSERT_NOW(a_status_range, out_valid, status == ST_OK || status == ST_EMPTY || status == ST_FULL)

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);
